// File: hdl/ssds_pkg.sv
// Shared types, codes and the digit font for the seven-segment decimal scanner.
// No dependencies; every other file of the block imports this package.
package ssds_pkg;

    localparam int DIGITS_MAX = 8;      // width of the select bus and store limit
    localparam int SCAN_W     = 3;      // scan index width
    localparam int CNT_W      = 4;      // digit count register width
    localparam int MAG_W      = 16;     // magnitude width (covers 32768)
    localparam int REM_W      = 4;      // decimal digit width
    localparam int STEP_W     = 4;      // bit counter of the serial divider
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [7:0] PAT_MINUS = 8'h02;
    localparam logic [7:0] PAT_BLANK = 8'h00;
    localparam logic [7:0] SEL_FIRST = 8'h80;

    localparam logic [REM_W:0] RADIX = 5'd10;

    // input kinds carried on tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMON_ANODE = 1'b1;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quo;
        logic [REM_W-1:0] rem;
    } t_div_stat;

    // segments a..g on bits 7..1, point on bit 0
    function automatic logic [7:0] font(input logic [REM_W-1:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'hFC;
            4'd1:    p = 8'h60;
            4'd2:    p = 8'hDA;
            4'd3:    p = 8'hF2;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'hB6;
            4'd6:    p = 8'hBE;
            4'd7:    p = 8'hE0;
            4'd8:    p = 8'hFE;
            4'd9:    p = 8'hF6;
            default: p = PAT_BLANK;
        endcase
        return p;
    endfunction

endpackage

// File: hdl/ssds_div10.sv
// Bit-serial restoring divider by ten: one quotient bit per cycle.
// Depends on ssds_pkg for widths and the status struct.
module ssds_div10 import ssds_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    output t_div_stat        o_stat
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [MAG_W-1:0]  r_quo, n_quo;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [REM_W:0]    trial;
    logic              ge;

    assign trial = {r_rem, r_quo[MAG_W-1]};
    assign ge    = (trial >= RADIX);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            // shift the dividend out at the top, quotient bits in at the bottom
            n_quo  = {r_quo[MAG_W-2:0], ge};
            n_rem  = ge ? REM_W'(trial - RADIX) : trial[REM_W-1:0];
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(MAG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_stat.done = r_done;
    assign o_stat.quo  = r_quo;
    assign o_stat.rem  = r_rem;

endmodule

// File: hdl/ssds_store.sv
// Digit pattern store: one write port, one read port for the scan.
// Depends on ssds_pkg for widths.
module ssds_store import ssds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [SCAN_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [SCAN_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    // always the full eight entries: the scan index may point past the digits in use
    logic [7:0] r_pat [DIGITS_MAX];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIGITS_MAX; k++) begin
                r_pat[k] <= PAT_BLANK;
            end
        end else if (i_we) begin
            r_pat[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_pat[i_raddr];

endmodule

// File: hdl/seven_segment_decimal_scanner_core.sv
// Seven-segment decimal scanner: a tick beat's result is registered and is ready in
// the cycle after acceptance. A write beat converts one decimal digit at a time
// (a start state, the serial divider's steps and a write-back), and the input is
// held off until every digit of the count has been written.
// Synchronous active-low reset clears the digit store, the scan index and the
// registers (digit count 8, common cathode).
module seven_segment_decimal_scanner_core import ssds_pkg::*; #(
    parameter int MAX_DIGITS = DIGITS_MAX
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // [15:0] value, [16] fill, rest zero
    input  logic                  s_axis_tuser,   // [0] func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata    // [7:0] segments, [15:8] digit_select
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DIGIT = 3'b010,
        S_DIV   = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_digit_count;
    logic              r_common_anode;
    logic [MAG_W-1:0]  r_mag, n_mag;
    logic              r_neg, n_neg;
    logic              r_fill, n_fill;
    logic              r_first, n_first;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [SCAN_W-1:0] r_scan, n_scan;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_seg, n_seg;
    logic [7:0]        r_sel, n_sel;

    logic              accept;
    logic              in_neg;
    logic [MAG_W-1:0]  in_val;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  scan_next;
    logic [CNT_W-1:0]  wpos;
    logic [7:0]        pat;
    logic              st_we;
    logic [SCAN_W-1:0] st_waddr;
    logic [7:0]        st_wdata;
    logic [7:0]        st_rdata;
    t_div_stat         div_stat;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_val        = s_axis_tdata[MAG_W-1:0];
    assign in_neg        = in_val[MAG_W-1];

    always_comb begin
        if (r_digit_count == '0) begin
            used = CNT_W'(1);
        end else if (r_digit_count > CNT_W'(MAX_DIGITS)) begin
            used = CNT_W'(MAX_DIGITS);
        end else begin
            used = r_digit_count;
        end
    end

    assign scan_next = {1'b0, r_scan} + CNT_W'(1);
    assign wpos      = r_used - r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count  <= CNT_W'(DIGITS_MAX);
            r_common_anode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DIGIT_COUNT:  r_digit_count  <= i_cfg_wdata;
                CFG_COMMON_ANODE: r_common_anode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_fill      = r_fill;
        n_first     = r_first;
        n_pos       = r_pos;
        n_used      = r_used;
        n_scan      = r_scan;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_seg       = r_seg;
        n_sel       = r_sel;
        st_we       = 1'b0;
        st_waddr    = '0;
        st_wdata    = PAT_BLANK;
        pat         = PAT_BLANK;

        case (r_state)
            S_IDLE: begin
                if (accept && s_axis_tuser == FUNC_TICK) begin
                    n_out_valid = 1'b1;
                    n_seg       = st_rdata;
                    n_sel       = SEL_FIRST >> r_scan;
                    if (!r_common_anode) begin
                        n_sel = ~n_sel;
                    end
                    n_scan = (scan_next >= used) ? '0 : scan_next[SCAN_W-1:0];
                end else if (accept) begin
                    n_used  = used;
                    n_fill  = s_axis_tdata[MAG_W];
                    n_mag   = in_neg ? (~in_val + MAG_W'(1)) : in_val;
                    n_neg   = in_neg;
                    n_first = 1'b0;
                    n_pos   = CNT_W'(1);
                    n_state = S_DIGIT;
                    if (in_neg && s_axis_tdata[MAG_W]) begin
                        // minus takes the leftmost digit
                        st_we    = 1'b1;
                        st_waddr = '0;
                        st_wdata = r_common_anode ? ~PAT_MINUS : PAT_MINUS;
                        n_neg    = 1'b0;
                        n_first  = 1'b1;
                        if (used == CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_DIGIT: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (r_mag != '0) begin
                        pat = font(div_stat.rem);
                    end else if (r_neg) begin
                        pat   = PAT_MINUS;
                        n_neg = 1'b0;
                    end else if (r_fill || r_pos == CNT_W'(1)) begin
                        pat = font('0);
                    end else begin
                        pat = PAT_BLANK;
                    end
                    st_we    = 1'b1;
                    st_waddr = wpos[SCAN_W-1:0];
                    st_wdata = r_common_anode ? ~pat : pat;
                    n_mag    = div_stat.quo;
                    n_pos    = r_pos + CNT_W'(1);
                    // advance while another digit still fits
                    n_state  = ((r_pos + CNT_W'(r_first)) < r_used) ? S_DIGIT : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_fill  <= n_fill;
        r_first <= n_first;
        r_pos   <= n_pos;
        r_used  <= n_used;
        r_seg   <= n_seg;
        r_sel   <= n_sel;
    end

    ssds_div10 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIGIT),
        .i_dividend (r_mag),
        .o_stat     (div_stat)
    );

    ssds_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (r_scan),
        .o_rdata (st_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_sel, r_seg};

endmodule
